/* rtl/pva_pkg.sv */
`timescale 1ns / 1ps
package pva_pkg;

    // field widths
    localparam int OP_W    = 1;
    localparam int NOTE_W  = 7;
    localparam int VEL_W   = 7;
    localparam int TIME_W  = 32;
    localparam int KIND_W  = 2;
    localparam int VOICE_W = 3;
    localparam int WORD_W  = 23;
    localparam int MASK_W  = 8;
    localparam int STACK_W = 4;
    localparam int DAC_W   = 16;

    // opcodes
    localparam logic [OP_W-1:0] OP_NOTE_ON  = 1'b0;
    localparam logic [OP_W-1:0] OP_NOTE_OFF = 1'b1;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_STARTED  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_IGNORED  = 2'd2;

    // pitch: note*276.6 rounded half up, split as note*276 + (6*note+5)/10
    localparam int PITCH_INT_W = 9;
    localparam logic [PITCH_INT_W-1:0] PITCH_INT = 9'd276;
    localparam int FRAC_W      = 10;
    localparam int RECIP_W     = 8;
    localparam logic [RECIP_W-1:0] RECIP_TEN = 8'd205;  // 205/2048 ~ 1/10, exact below 1029
    localparam int RECIP_SHIFT = 11;
    localparam int FRAC_PROD_W = FRAC_W + RECIP_W;

endpackage

/* rtl/pva_in_if.sv */
`timescale 1ns / 1ps
interface pva_in_if import pva_pkg::*;;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  velocity;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, opcode, note, velocity, now_ms, input ready);
    modport sink   (input valid, opcode, note, velocity, now_ms, output ready);
endinterface

/* rtl/pva_out_if.sv */
`timescale 1ns / 1ps
interface pva_out_if import pva_pkg::*;;
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [VOICE_W-1:0] voice;
    logic [WORD_W-1:0]  cv_word;
    logic [WORD_W-1:0]  vel_word;
    logic [MASK_W-1:0]  gate_mask;
    logic               last;

    modport source (output valid, kind, voice, cv_word, vel_word, gate_mask, last,
                    input ready);
    modport sink   (input valid, kind, voice, cv_word, vel_word, gate_mask, last,
                    output ready);
endinterface

/* rtl/poly_voice_allocator_core.sv */
`timescale 1ns / 1ps
// sequence: note-off scans every voice in ST_OFF, the last scan step loading the result register;
// note-on first checks for a duplicate in ST_DUP (stack of one), then per voice searches for
// a free voice in ST_FREE, scans for the oldest in ST_STEAL when stealing, and writes in ST_TAKE
// throughput: one item at a time, the next taken in the cycle after the last result is accepted
// reset: all gates, notes, start times and the round-robin pointer cleared, stack size 1
module poly_voice_allocator_core import pva_pkg::*; #(
    parameter int VOICE_COUNT = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [STACK_W-1:0] cfg_wdata,
    pva_in_if.sink             note_in,
    pva_out_if.source          result
);

    localparam int VW = $clog2(VOICE_COUNT);
    localparam logic [VW-1:0] LAST_IDX = VW'(VOICE_COUNT - 1);

    // sequencer codes
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_OFF   = 3'd1;
    localparam logic [2:0] ST_DUP   = 3'd2;
    localparam logic [2:0] ST_FREE  = 3'd3;
    localparam logic [2:0] ST_STEAL = 3'd4;
    localparam logic [2:0] ST_TAKE  = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0] state_reg, state_next;

    // voice state
    logic [VOICE_COUNT-1:0] gate_reg, gate_next;
    logic [NOTE_W-1:0]      vnote_reg [VOICE_COUNT];
    logic [NOTE_W-1:0]      vnote_next [VOICE_COUNT];
    logic [TIME_W-1:0]      vtime_reg [VOICE_COUNT];
    logic [TIME_W-1:0]      vtime_next [VOICE_COUNT];
    logic [VW-1:0]          ptr_reg, ptr_next;
    logic [STACK_W-1:0]     stack_reg, stack_next;

    // item registers
    logic [NOTE_W-1:0]      note_reg, note_next;
    logic [VEL_W-1:0]       vel_reg, vel_next;
    logic [TIME_W-1:0]      now_reg, now_next;
    logic [DAC_W-1:0]       base_reg, base_next;
    logic [FRAC_W-1:0]      frac_reg, frac_next;
    logic [STACK_W-1:0]     rem_reg, rem_next;

    // scan registers
    logic [VW-1:0]          pos_reg, pos_next;
    logic [VW-1:0]          cnt_reg, cnt_next;
    logic [VW-1:0]          sel_reg, sel_next;
    logic [TIME_W-1:0]      oldest_reg, oldest_next;

    // result register
    logic                   ovalid_reg, ovalid_next;
    logic [KIND_W-1:0]      okind_reg, okind_next;
    logic [VOICE_W-1:0]     ovoice_reg, ovoice_next;
    logic [WORD_W-1:0]      ocv_reg, ocv_next;
    logic [WORD_W-1:0]      ovel_reg, ovel_next;
    logic [MASK_W-1:0]      omask_reg, omask_next;
    logic                   olast_reg, olast_next;

    logic [STACK_W-1:0]     eff_stack;
    logic [FRAC_PROD_W-1:0] frac_prod;
    logic [DAC_W-1:0]       mv;
    logic [DAC_W-1:0]       vel_dac;
    logic                   older;
    logic                   note_hit;
    logic [VW-1:0]          pos_inc;
    logic [VW-1:0]          sel_inc;

    assign note_in.ready    = (state_reg == ST_IDLE);
    assign result.valid     = ovalid_reg;
    assign result.kind      = okind_reg;
    assign result.voice     = ovoice_reg;
    assign result.cv_word   = ocv_reg;
    assign result.vel_word  = ovel_reg;
    assign result.gate_mask = omask_reg;
    assign result.last      = olast_reg;

    // stack size clamped to 1..VOICE_COUNT
    always_comb
    begin
        if (stack_reg == '0)
            eff_stack = STACK_W'(1);
        else if (stack_reg > STACK_W'(VOICE_COUNT))
            eff_stack = STACK_W'(VOICE_COUNT);
        else
            eff_stack = stack_reg;
    end

    // pitch and velocity words from the latched item
    assign frac_prod = FRAC_PROD_W'(frac_reg) * FRAC_PROD_W'(RECIP_TEN);
    assign mv        = base_reg + DAC_W'(frac_prod >> RECIP_SHIFT);
    assign vel_dac   = {1'b0, vel_reg, 8'd0};

    // shared compare unit and scan helpers
    assign older    = vtime_reg[pos_reg] < oldest_reg;
    assign note_hit = (vnote_reg[pos_reg] == note_reg);
    assign pos_inc  = (pos_reg == LAST_IDX) ? '0 : pos_reg + VW'(1);
    assign sel_inc  = (sel_reg == LAST_IDX) ? '0 : sel_reg + VW'(1);

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        gate_next   = gate_reg;
        vnote_next  = vnote_reg;
        vtime_next  = vtime_reg;
        ptr_next    = ptr_reg;
        stack_next  = stack_reg;
        note_next   = note_reg;
        vel_next    = vel_reg;
        now_next    = now_reg;
        base_next   = base_reg;
        frac_next   = frac_reg;
        rem_next    = rem_reg;
        pos_next    = pos_reg;
        cnt_next    = cnt_reg;
        sel_next    = sel_reg;
        oldest_next = oldest_reg;
        ovalid_next = ovalid_reg;
        okind_next  = okind_reg;
        ovoice_next = ovoice_reg;
        ocv_next    = ocv_reg;
        ovel_next   = ovel_reg;
        omask_next  = omask_reg;
        olast_next  = olast_reg;

        if (cfg_we)
            stack_next = cfg_wdata;

        case (state_reg)
            ST_IDLE:
            begin
                if (note_in.valid)
                begin
                    note_next = note_in.note;
                    vel_next  = note_in.velocity;
                    now_next  = note_in.now_ms;
                    base_next = DAC_W'(note_in.note) * DAC_W'(PITCH_INT);
                    frac_next = FRAC_W'(note_in.note) * FRAC_W'(6) + FRAC_W'(5);
                    rem_next  = eff_stack;
                    cnt_next  = '0;
                    if (note_in.opcode == OP_NOTE_OFF)
                    begin
                        pos_next   = '0;
                        state_next = ST_OFF;
                    end
                    else if (eff_stack == STACK_W'(1))
                    begin
                        pos_next   = '0;
                        state_next = ST_DUP;
                    end
                    else
                    begin
                        pos_next   = ptr_reg;
                        state_next = ST_FREE;
                    end
                end
            end

            // release every voice holding the note
            ST_OFF:
            begin
                if (note_hit)
                begin
                    gate_next[pos_reg]  = 1'b0;
                    vtime_next[pos_reg] = '0;
                end
                pos_next = pos_inc;
                if (pos_reg == LAST_IDX)
                begin
                    ovalid_next = 1'b1;
                    okind_next  = KIND_RELEASED;
                    ovoice_next = '0;
                    ocv_next    = '0;
                    ovel_next   = '0;
                    omask_next  = MASK_W'(gate_next);
                    olast_next  = 1'b1;
                    state_next  = ST_OUT;
                end
            end

            // a gated voice already playing the note: ignore
            ST_DUP:
            begin
                pos_next = pos_inc;
                if (note_hit && gate_reg[pos_reg])
                begin
                    ovalid_next = 1'b1;
                    okind_next  = KIND_IGNORED;
                    ovoice_next = '0;
                    ocv_next    = '0;
                    ovel_next   = '0;
                    omask_next  = MASK_W'(gate_reg);
                    olast_next  = 1'b1;
                    state_next  = ST_OUT;
                end
                else if (pos_reg == LAST_IDX)
                begin
                    pos_next   = ptr_reg;
                    cnt_next   = '0;
                    state_next = ST_FREE;
                end
            end

            // round-robin search for a free voice
            ST_FREE:
            begin
                if (!gate_reg[pos_reg])
                begin
                    sel_next   = pos_reg;
                    state_next = ST_TAKE;
                end
                else if (cnt_reg == LAST_IDX)
                begin
                    pos_next    = '0;
                    sel_next    = '0;
                    oldest_next = now_reg;
                    state_next  = ST_STEAL;
                end
                else
                begin
                    pos_next = pos_inc;
                    cnt_next = cnt_reg + VW'(1);
                end
            end

            // oldest voice, strict compare from the current time
            ST_STEAL:
            begin
                if (older)
                begin
                    oldest_next = vtime_reg[pos_reg];
                    sel_next    = pos_reg;
                end
                pos_next = pos_inc;
                if (pos_reg == LAST_IDX)
                    state_next = ST_TAKE;
            end

            // start the chosen voice and load the result
            ST_TAKE:
            begin
                gate_next[sel_reg]  = 1'b1;
                vnote_next[sel_reg] = note_reg;
                vtime_next[sel_reg] = now_reg;
                ptr_next            = sel_inc;
                ovalid_next = 1'b1;
                okind_next  = KIND_STARTED;
                ovoice_next = VOICE_W'(sel_reg);
                ocv_next    = {VOICE_W'(sel_reg), mv, 4'd0};
                ovel_next   = {VOICE_W'(sel_reg), vel_dac, 4'd0};
                omask_next  = MASK_W'(gate_next);
                olast_next  = (rem_reg == STACK_W'(1));
                state_next  = ST_OUT;
            end

            // hold the result until taken
            ST_OUT:
            begin
                if (result.ready)
                begin
                    ovalid_next = 1'b0;
                    if (olast_reg)
                        state_next = ST_IDLE;
                    else
                    begin
                        rem_next   = rem_reg - STACK_W'(1);
                        pos_next   = ptr_reg;
                        cnt_next   = '0;
                        state_next = ST_FREE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and voice state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            gate_reg   <= '0;
            ptr_reg    <= '0;
            stack_reg  <= STACK_W'(1);
            ovalid_reg <= 1'b0;
            for (int i = 0; i < VOICE_COUNT; i++)
            begin
                vnote_reg[i] <= '0;
                vtime_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            gate_reg   <= gate_next;
            ptr_reg    <= ptr_next;
            stack_reg  <= stack_next;
            ovalid_reg <= ovalid_next;
            vnote_reg  <= vnote_next;
            vtime_reg  <= vtime_next;
        end
    end

    // item, scan and result payload
    always_ff @(posedge clk)
    begin
        note_reg   <= note_next;
        vel_reg    <= vel_next;
        now_reg    <= now_next;
        base_reg   <= base_next;
        frac_reg   <= frac_next;
        rem_reg    <= rem_next;
        pos_reg    <= pos_next;
        cnt_reg    <= cnt_next;
        sel_reg    <= sel_next;
        oldest_reg <= oldest_next;
        okind_reg  <= okind_next;
        ovoice_reg <= ovoice_next;
        ocv_reg    <= ocv_next;
        ovel_reg   <= ovel_next;
        omask_reg  <= omask_next;
        olast_reg  <= olast_next;
    end

endmodule

/* sim/poly_voice_allocator_core_tb.sv */
`timescale 1ns / 1ps
module poly_voice_allocator_core_tb;
    import pva_pkg::*;

    localparam int NV          = 8;
    localparam int IDLE_LIMIT  = 3000;
    localparam int SETTLE      = 160;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 43;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VOICE_W-1:0] voice;
        logic [WORD_W-1:0]  cv_word;
        logic [WORD_W-1:0]  vel_word;
        logic [MASK_W-1:0]  gate_mask;
        logic               last;
    } voice_result_t;

    // mirror of the voice table and the dac words it should produce
    class voice_scoreboard;
        bit                 gate [NV];
        bit [NOTE_W-1:0]    vnote [NV];
        bit [TIME_W-1:0]    vstart [NV];
        bit [VOICE_W-1:0]   rr_ptr;
        bit [STACK_W-1:0]   stack_reg;
        voice_result_t      expected_q [$];
        int                 errors;
        int                 checked;
        int                 n_started;
        int                 n_released;
        int                 n_ignored;

        function new();
            for (int v = 0; v < NV; v++)
            begin
                gate[v]   = 1'b0;
                vnote[v]  = '0;
                vstart[v] = '0;
            end
            rr_ptr    = '0;
            stack_reg = 4'd1;
        endfunction

        function void set_stack(bit [STACK_W-1:0] value);
            stack_reg = value;
        endfunction

        function bit [MASK_W-1:0] gates_now();
            bit [MASK_W-1:0] m;
            m = '0;
            for (int v = 0; v < NV; v++)
                m[v] = gate[v];
            return m;
        endfunction

        function void push(bit [KIND_W-1:0] kind, bit [VOICE_W-1:0] voice,
                           bit [WORD_W-1:0] cvw, bit [WORD_W-1:0] velw, bit last);
            voice_result_t r;
            r.kind      = kind;
            r.voice     = voice;
            r.cv_word   = cvw;
            r.vel_word  = velw;
            r.gate_mask = gates_now();
            r.last      = last;
            expected_q.push_back(r);
        endfunction

        // first free voice from the pointer, else the oldest with a strict compare
        function bit [VOICE_W-1:0] pick_voice(bit [TIME_W-1:0] now);
            bit [TIME_W-1:0] min_start;
            int              oldest;
            int              n;
            for (int i = 0; i < NV; i++)
            begin
                n = (int'(rr_ptr) + i) % NV;
                if (!gate[n])
                begin
                    rr_ptr = VOICE_W'((n + 1) % NV);
                    return VOICE_W'(n);
                end
            end
            min_start = now;
            oldest    = 0;
            for (int i = 0; i < NV; i++)
            begin
                if (vstart[i] < min_start)
                begin
                    min_start = vstart[i];
                    oldest    = i;
                end
            end
            rr_ptr = VOICE_W'((oldest + 1) % NV);
            return VOICE_W'(oldest);
        endfunction

        function void note_event(bit [OP_W-1:0] op, bit [NOTE_W-1:0] nt,
                                 bit [VEL_W-1:0] vel, bit [TIME_W-1:0] now);
            int               eff;
            bit [VOICE_W-1:0] n;
            bit [DAC_W-1:0]   mv;
            bit [DAC_W-1:0]   velv;
            // note off releases every voice holding the note, gated or not
            if (op == OP_NOTE_OFF)
            begin
                for (int v = 0; v < NV; v++)
                begin
                    if (vnote[v] == nt)
                    begin
                        gate[v]   = 1'b0;
                        vstart[v] = '0;
                    end
                end
                push(KIND_RELEASED, '0, '0, '0, 1'b1);
                return;
            end
            eff = int'(stack_reg);
            if (eff < 1)
                eff = 1;
            if (eff > NV)
                eff = NV;
            // duplicate gated note with no stacking is dropped
            if (eff < 2)
            begin
                for (int v = 0; v < NV; v++)
                begin
                    if (vnote[v] == nt && gate[v])
                    begin
                        push(KIND_IGNORED, '0, '0, '0, 1'b1);
                        return;
                    end
                end
            end
            for (int k = 0; k < eff; k++)
            begin
                n = pick_voice(now);
                vstart[n] = now;
                vnote[n]  = nt;
                gate[n]   = 1'b1;
                mv   = DAC_W'((int'(nt) * 2766 + 5) / 10);
                velv = DAC_W'(int'(vel) * 256);
                push(KIND_STARTED, n, {n, mv, 4'h0}, {n, velv, 4'h0}, k == eff - 1);
            end
        endfunction

        function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_output(voice_result_t got);
            voice_result_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none actual kind %0h voice %0h",
                         $time, got.kind, got.voice);
                return;
            end
            want = expected_q.pop_front();
            cmp_field("kind", 32'(want.kind), 32'(got.kind));
            cmp_field("voice", 32'(want.voice), 32'(got.voice));
            cmp_field("cv_word", 32'(want.cv_word), 32'(got.cv_word));
            cmp_field("vel_word", 32'(want.vel_word), 32'(got.vel_word));
            cmp_field("gate_mask", 32'(want.gate_mask), 32'(got.gate_mask));
            cmp_field("last", 32'(want.last), 32'(got.last));
            checked++;
            case (want.kind)
                KIND_STARTED:  n_started++;
                KIND_RELEASED: n_released++;
                default:       n_ignored++;
            endcase
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [STACK_W-1:0] cfg_wdata;

    pva_in_if  in_ch ();
    pva_out_if res_ch ();

    voice_scoreboard sb = new();

    int events_sent;
    int stack_writes;
    int idle_cycles;
    int hold_len;
    int no_idle;

    poly_voice_allocator_core #(
        .VOICE_COUNT (NV)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .note_in   (in_ch),
        .result    (res_ch)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // watchdog on cycles with no item moving on either channel
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: timeout, no item moved for %0d cycles", $time, IDLE_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // result side: random stalls, one long hold-off on request
    initial
    begin : result_sink
        int gap;
        voice_result_t got;
        res_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = (no_idle != 0) ? 0 : int'($urandom_range(0, 9));
            gap = gap + hold_len;
            hold_len = 0;
            repeat (gap)
            begin
                @(negedge clk);
                res_ch.ready <= 1'b0;
            end
            @(negedge clk);
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_ch.valid);
            got.kind      = res_ch.kind;
            got.voice     = res_ch.voice;
            got.cv_word   = res_ch.cv_word;
            got.vel_word  = res_ch.vel_word;
            got.gate_mask = res_ch.gate_mask;
            got.last      = res_ch.last;
            sb.check_output(got);
        end
    end

    // offer one event after a random gap and wait for it to be taken
    task automatic send_event(input logic [OP_W-1:0] op, input logic [NOTE_W-1:0] nt,
                              input logic [VEL_W-1:0] vel, input logic [TIME_W-1:0] now);
        int gap;
        gap = (no_idle != 0) ? 0 : int'($urandom_range(0, 9));
        repeat (gap)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge clk);
        in_ch.valid    <= 1'b1;
        in_ch.opcode   <= op;
        in_ch.note     <= nt;
        in_ch.velocity <= vel;
        in_ch.now_ms   <= now;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_event(op, nt, vel, now);
        events_sent++;
    endtask

    // stop offering, wait for every result, then let the block settle
    task automatic drain_and_settle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE)
            @(posedge clk);
    endtask

    task automatic write_stack(input logic [STACK_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.set_stack(value);
        stack_writes++;
    endtask

    initial
    begin : stimulus
        logic [STACK_W-1:0] phase_stack [PHASES];
        logic [OP_W-1:0]    op;
        logic [NOTE_W-1:0]  nt;
        logic [NOTE_W-1:0]  base;
        logic [TIME_W-1:0]  clock_ms;
        logic [TIME_W-1:0]  now;
        int                 r;

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        in_ch.valid    = 1'b0;
        in_ch.opcode   = OP_NOTE_ON;
        in_ch.note     = '0;
        in_ch.velocity = '0;
        in_ch.now_ms   = '0;
        events_sent    = 0;
        stack_writes   = 0;
        hold_len       = 0;
        no_idle        = 0;
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, duplicate, note off with and without a match
        send_event(OP_NOTE_ON, 7'd0, 7'd0, 32'h0000_0000);
        send_event(OP_NOTE_ON, 7'd127, 7'd127, 32'hFFFF_FFFF);
        send_event(OP_NOTE_ON, 7'd127, 7'd5, 32'd10);
        send_event(OP_NOTE_OFF, 7'd99, 7'd127, 32'd11);
        send_event(OP_NOTE_OFF, 7'd0, 7'd0, 32'd12);
        // fill the free voices, the last one steals the oldest
        for (int i = 0; i < 8; i++)
            send_event(OP_NOTE_ON, NOTE_W'(20 + i), VEL_W'(64 + i), TIME_W'(200 + i));
        // time earlier than every start time: voice 0 is taken
        send_event(OP_NOTE_ON, 7'd30, 7'd1, 32'd5);
        send_event(OP_NOTE_OFF, 7'd127, 7'd0, 32'd300);
        drain_and_settle();

        // directed: full unison stack, stealing into a table of equal times
        write_stack(4'd8);
        send_event(OP_NOTE_ON, 7'd60, 7'd100, 32'd1000);
        send_event(OP_NOTE_ON, 7'd61, 7'd42, 32'd999);
        send_event(OP_NOTE_OFF, 7'd61, 7'd0, 32'd1001);
        send_event(OP_NOTE_OFF, 7'd60, 7'd0, 32'd1002);
        drain_and_settle();

        // random phases over stack settings, out of range ones among them
        phase_stack = '{4'd0, 4'd2, 4'd8, 4'd15, 4'd3, 4'd1, 4'd0, 4'd5, 4'd9, 4'd0};
        phase_stack[6] = STACK_W'($urandom_range(0, 15));
        phase_stack[9] = STACK_W'($urandom_range(0, 15));
        clock_ms = $urandom;
        for (int p = 0; p < PHASES; p++)
        begin
            write_stack(phase_stack[p]);
            base = NOTE_W'($urandom_range(0, 116));
            no_idle = (p == 5) ? 1 : 0;
            // long receiver hold-off so the block backs up into its input
            if (p == 1)
                hold_len = HOLD_CYCLES;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // sender waits for everything to come out once mid-phase
                if (p == 3 && i == 20)
                begin
                    @(negedge clk);
                    in_ch.valid <= 1'b0;
                    while (sb.expected_q.size() != 0)
                        @(posedge clk);
                end
                r  = int'($urandom_range(0, 99));
                op = (r < 60) ? OP_NOTE_ON : OP_NOTE_OFF;
                if ($urandom_range(0, 9) == 0)
                    nt = NOTE_W'($urandom_range(0, 127));
                else
                    nt = base + NOTE_W'($urandom_range(0, 11));
                r = int'($urandom_range(0, 99));
                if (r < 8)
                begin
                    now = $urandom;
                end
                else if (r < 13)
                begin
                    now = clock_ms;
                end
                else
                begin
                    clock_ms = clock_ms + $urandom_range(1, 40);
                    now = clock_ms;
                end
                send_event(op, nt, VEL_W'($urandom_range(0, 127)), now);
            end
            drain_and_settle();
        end
        no_idle = 0;

        $display("Run covered %0d events and %0d results over %0d stack settings",
                 events_sent, sb.checked, stack_writes);
        $display("  voice starts %0d, releases %0d, ignored duplicates %0d",
                 sb.n_started, sb.n_released, sb.n_ignored);
        if (sb.errors == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/pva_pkg.sv
rtl/pva_in_if.sv
rtl/pva_out_if.sv
rtl/poly_voice_allocator_core.sv
sim/poly_voice_allocator_core_tb.sv
